FILE: rtl/sisi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stable integer sort package
// Shared types, constants and the sort key mapping for the sorter and its cells.
// ----------------------------------------------------------------------------
package sisi_pkg;

	localparam int VALUE_W   = 32;
	localparam int OUT_POS_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DESCENDING  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IS_UNSIGNED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WITH_INDEX  = 2'd2;

	typedef enum logic [1:0] {
		OP_HOLD  = 2'd0,
		OP_LOAD  = 2'd1,
		OP_SORT  = 2'd2,
		OP_DRAIN = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     odd_phase;
		logic     descending;
		logic     is_unsigned;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_SORT  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	// Maps a raw element onto a key whose unsigned ascending order is the wanted order.
	function automatic logic [VALUE_W-1:0] sort_key(input logic [VALUE_W-1:0] v,
			input logic descending, input logic is_unsigned);
		logic [VALUE_W-1:0] k;
		k = is_unsigned ? v : {~v[VALUE_W-1], v[VALUE_W-2:0]};
		return descending ? ~k : k;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/sisi_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stable integer sort channels
// Valid/ready channels for input elements and sorted results.
// ----------------------------------------------------------------------------
interface sisi_in_if;
	logic                         valid;
	logic                         ready;
	logic [sisi_pkg::VALUE_W-1:0] value;
	logic                         last_in;

	modport source (output valid, output value, output last_in, input ready);
	modport sink (input valid, input value, input last_in, output ready);
endinterface

interface sisi_out_if;
	logic                           valid;
	logic                           ready;
	logic [sisi_pkg::VALUE_W-1:0]   sorted_value;
	logic [sisi_pkg::OUT_POS_W-1:0] orig_position;
	logic                           last_out;

	modport source (output valid, output sorted_value, output orig_position,
		output last_out, input ready);
	modport sink (input valid, input sorted_value, input orig_position,
		input last_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/sisi_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sort cell
// One slot of the chain: shifts in, shifts out, or compare-exchanges with a neighbour.
// ----------------------------------------------------------------------------
module sisi_cell #(
	parameter int IDX = 0,
	parameter int PW  = 7
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire sisi_pkg::cell_ctl_t          ctl,
	input  wire logic [sisi_pkg::VALUE_W-1:0] left_value,
	input  wire logic [PW-1:0]                left_pos,
	input  wire logic                         left_valid,
	input  wire logic [sisi_pkg::VALUE_W-1:0] right_value,
	input  wire logic [PW-1:0]                right_pos,
	input  wire logic                         right_valid,
	output logic [sisi_pkg::VALUE_W-1:0]      value,
	output logic [PW-1:0]                     pos,
	output logic                              valid
);

	localparam bit EVEN_IDX = (IDX % 2) == 0;
	localparam bit HAS_LEFT = IDX > 0;

	logic [sisi_pkg::VALUE_W-1:0] value_q;
	logic [PW-1:0]                pos_q;
	logic                         valid_q;
	logic                         is_lower;
	logic                         swap_right;
	logic                         swap_left;
	logic                         take_left;
	logic                         take_right;

	// Strict order: key first, then arrival position, which makes the sort stable.
	function automatic logic goes_before(input logic [sisi_pkg::VALUE_W-1:0] va,
			input logic [PW-1:0] pa, input logic [sisi_pkg::VALUE_W-1:0] vb,
			input logic [PW-1:0] pb);
		logic [sisi_pkg::VALUE_W-1:0] ka;
		logic [sisi_pkg::VALUE_W-1:0] kb;
		ka = sisi_pkg::sort_key(va, ctl.descending, ctl.is_unsigned);
		kb = sisi_pkg::sort_key(vb, ctl.descending, ctl.is_unsigned);
		if (ka != kb) begin
			return ka < kb;
		end
		return pa < pb;
	endfunction

	assign is_lower   = EVEN_IDX ? !ctl.odd_phase : ctl.odd_phase;
	assign swap_right = valid_q && right_valid && goes_before(right_value, right_pos, value_q, pos_q);
	assign swap_left  = HAS_LEFT && valid_q && left_valid
		&& goes_before(value_q, pos_q, left_value, left_pos);

	always_comb begin
		take_left  = 1'b0;
		take_right = 1'b0;
		case (ctl.op)
			sisi_pkg::OP_LOAD: begin
				take_left = 1'b1;
			end
			sisi_pkg::OP_DRAIN: begin
				take_right = 1'b1;
			end
			sisi_pkg::OP_SORT: begin
				take_right = is_lower && swap_right;
				take_left  = !is_lower && swap_left;
			end
			default: begin
				take_left  = 1'b0;
				take_right = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_left) begin
			valid_q <= left_valid;
		end else if (take_right) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_left) begin
			value_q <= left_value;
			pos_q   <= left_pos;
		end else if (take_right) begin
			value_q <= right_value;
			pos_q   <= right_pos;
		end
	end

	assign value = value_q;
	assign pos   = pos_q;
	assign valid = valid_q;

endmodule
`default_nettype wire

FILE: rtl/stable_int_sort_with_index_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stable integer sort with permutation index
// Collects a group of 32-bit elements and returns them in stable sorted order.
// ----------------------------------------------------------------------------
// Usage. Elements arrive on in_ch, one item per accepted handshake, the final
// element of a group marked by last_in. A group also closes by itself when its
// MAX_ITEMS-th element arrives. Sorted results leave on out_ch, each with its
// 1-based arrival position (or zero while with_index is clear) and last_out
// on the final result of the group.
// A group of n elements loads one item per cycle while in_ch.valid is high,
// then goes through n odd-even transposition passes across the cell chain,
// then the results leave, one per cycle while out_ch.ready is high. The next
// group is taken once the last result has been accepted, so loading, sorting
// and draining of different groups never overlap.
// A stall on out_ch simply holds the head cell; nothing is lost.
// Reset empties the chain and the group count, and loads the registers with
// ascending, signed, index on. Register writes act at once, also mid-group.
// ----------------------------------------------------------------------------
module stable_int_sort_with_index_unit #(
	parameter int MAX_ITEMS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [sisi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sisi_pkg::CFG_DATA_W-1:0] cfg_wdata,
	sisi_in_if.sink                              in_ch,
	sisi_out_if.source                           out_ch
);

	// Count and positions run up to MAX_ITEMS inclusive.
	localparam int CW = $clog2(MAX_ITEMS + 1);

	sisi_pkg::state_t    state_q;
	sisi_pkg::cell_ctl_t ctl;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       phase_q;
	logic                descending_q;
	logic                is_unsigned_q;
	logic                with_index_q;
	logic                in_fire;
	logic                out_fire;
	logic                group_closes;
	logic                sort_done;
	logic [CW-1:0]       new_pos;

	logic [sisi_pkg::VALUE_W-1:0] cell_value [MAX_ITEMS];
	logic [CW-1:0]                cell_pos   [MAX_ITEMS];
	logic                         cell_valid [MAX_ITEMS];

	logic [CW+sisi_pkg::OUT_POS_W-1:0] head_pos_wide;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q  <= 1'b0;
			is_unsigned_q <= 1'b0;
			with_index_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				sisi_pkg::REG_DESCENDING: begin
					descending_q <= cfg_wdata[0];
				end
				sisi_pkg::REG_IS_UNSIGNED: begin
					is_unsigned_q <= cfg_wdata[0];
				end
				sisi_pkg::REG_WITH_INDEX: begin
					with_index_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign in_ch.ready  = (state_q == sisi_pkg::ST_LOAD);
	assign in_fire      = in_ch.valid && in_ch.ready;
	assign out_fire     = out_ch.valid && out_ch.ready;
	assign new_pos      = count_q + CW'(1);
	assign group_closes = in_ch.last_in || (count_q == CW'(MAX_ITEMS - 1));
	// n elements are fully ordered after n transposition passes.
	assign sort_done    = (phase_q == count_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sisi_pkg::ST_LOAD;
			count_q <= '0;
			phase_q <= '0;
		end else begin
			case (state_q)
				sisi_pkg::ST_LOAD: begin
					if (in_fire) begin
						count_q <= new_pos;
						phase_q <= '0;
						if (group_closes) begin
							state_q <= sisi_pkg::ST_SORT;
						end
					end
				end
				sisi_pkg::ST_SORT: begin
					phase_q <= phase_q + CW'(1);
					if (sort_done) begin
						state_q <= sisi_pkg::ST_DRAIN;
					end
				end
				sisi_pkg::ST_DRAIN: begin
					if (out_fire && out_ch.last_out) begin
						state_q <= sisi_pkg::ST_LOAD;
						count_q <= '0;
					end
				end
				default: begin
					state_q <= sisi_pkg::ST_LOAD;
				end
			endcase
		end
	end

	always_comb begin
		ctl.op          = sisi_pkg::OP_HOLD;
		ctl.odd_phase   = phase_q[0];
		ctl.descending  = descending_q;
		ctl.is_unsigned = is_unsigned_q;
		if (state_q == sisi_pkg::ST_LOAD && in_fire) begin
			ctl.op = sisi_pkg::OP_LOAD;
		end else if (state_q == sisi_pkg::ST_SORT) begin
			ctl.op = sisi_pkg::OP_SORT;
		end else if (state_q == sisi_pkg::ST_DRAIN && out_fire) begin
			ctl.op = sisi_pkg::OP_DRAIN;
		end
	end

	// The chain: new elements enter at cell 0 and push the others up; after
	// sorting, cell 0 holds the next result and the chain shifts down.
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic [sisi_pkg::VALUE_W-1:0] l_value;
		logic [CW-1:0]                l_pos;
		logic                         l_valid;
		logic [sisi_pkg::VALUE_W-1:0] r_value;
		logic [CW-1:0]                r_pos;
		logic                         r_valid;

		if (i == 0) begin : g_head
			assign l_value = in_ch.value;
			assign l_pos   = new_pos;
			assign l_valid = 1'b1;
		end else begin : g_mid
			assign l_value = cell_value[i-1];
			assign l_pos   = cell_pos[i-1];
			assign l_valid = cell_valid[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign r_value = '0;
			assign r_pos   = '0;
			assign r_valid = 1'b0;
		end else begin : g_body
			assign r_value = cell_value[i+1];
			assign r_pos   = cell_pos[i+1];
			assign r_valid = cell_valid[i+1];
		end

		sisi_cell #(
			.IDX (i),
			.PW  (CW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_value  (l_value),
			.left_pos    (l_pos),
			.left_valid  (l_valid),
			.right_value (r_value),
			.right_pos   (r_pos),
			.right_valid (r_valid),
			.value       (cell_value[i]),
			.pos         (cell_pos[i]),
			.valid       (cell_valid[i])
		);
	end

	// Results come straight from the head cell's registers.
	assign head_pos_wide        = (CW + sisi_pkg::OUT_POS_W)'(cell_pos[0]);
	assign out_ch.valid         = (state_q == sisi_pkg::ST_DRAIN) && cell_valid[0];
	assign out_ch.sorted_value  = cell_value[0];
	assign out_ch.orig_position = with_index_q ? head_pos_wide[sisi_pkg::OUT_POS_W-1:0] : '0;
	assign out_ch.last_out      = !cell_valid[1];

endmodule
`default_nettype wire
